@@ src/spmw_pkg.sv @@
// Shared constants, register codes and stage types of the pixel mirror writer.
package spmw_pkg;

	// Coordinate and register widths
	localparam int COORD_BITS = 16;
	localparam int OUT_COORD_BITS = 16;
	localparam int CFG_BITS = 17;
	localparam int DEG_BITS = 8;
	localparam int COLOR_BITS = 32;
	localparam int DIGIT_BITS = 8;
	localparam int IDX_BITS = 3;

	localparam logic [COLOR_BITS-1:0] STRIPE_OFS = 32'd8;

	// Symmetry modes
	localparam logic [3:0] MODE_NONE      = 4'd0;
	localparam logic [3:0] MODE_XAXIS     = 4'd1;
	localparam logic [3:0] MODE_YAXIS     = 4'd2;
	localparam logic [3:0] MODE_XYAXIS    = 4'd3;
	localparam logic [3:0] MODE_ORIGIN    = 4'd4;
	localparam logic [3:0] MODE_XBASIN    = 4'd5;
	localparam logic [3:0] MODE_XYBASIN   = 4'd6;
	localparam logic [3:0] MODE_XBASIN_S  = 4'd7;
	localparam logic [3:0] MODE_XYBASIN_S = 4'd8;

	// Register indexes
	localparam logic [IDX_BITS-1:0] REG_MODE   = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_XSUM   = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_YSUM   = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_XLOW   = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_YLOW   = 3'd4;
	localparam logic [IDX_BITS-1:0] REG_WIDTH  = 3'd5;
	localparam logic [IDX_BITS-1:0] REG_HEIGHT = 3'd6;
	localparam logic [IDX_BITS-1:0] REG_DEGREE = 3'd7;

	typedef struct packed {
		logic [3:0]          mode;
		logic [CFG_BITS-1:0] x_sum;
		logic [CFG_BITS-1:0] y_sum;
		logic [CFG_BITS-1:0] x_low;
		logic [CFG_BITS-1:0] y_low;
		logic [CFG_BITS-1:0] width;
		logic [CFG_BITS-1:0] height;
		logic [DEG_BITS-1:0] degree;
	} cfg_t;

	// One item as it travels down the pipeline
	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [CFG_BITS:0]     xd;
		logic [CFG_BITS:0]     yd;
		logic [COORD_BITS-1:0] xm;
		logic [COORD_BITS-1:0] ym;
		logic [3:0]            mode;
		logic [3:0]            mask;
		logic                  bx;
		logic                  bxy;
		logic                  stripe;
		logic [COLOR_BITS-1:0] c;
		logic [COLOR_BITS-1:0] cu;
		logic [COLOR_BITS-1:0] c1;
		logic [COLOR_BITS-1:0] a1;
		logic [COLOR_BITS-1:0] a2;
		logic [DEG_BITS-1:0]   ra;
		logic [DEG_BITS-1:0]   rb;
	} pipe_t;

endpackage

@@ src/spmw_prep.sv @@
// Entry logic: coordinate mirror differences, stripe and effective mode.
module spmw_prep import spmw_pkg::*; (
	input  logic [15:0] px,
	input  logic [15:0] py,
	input  logic [31:0] pcolor,
	input  cfg_t        cfg,
	output pipe_t       item
);

	logic [3:0] m;
	logic       stripe;

	always_comb begin
		item = '0;
		m = cfg.mode;
		stripe = (m == MODE_XBASIN_S || m == MODE_XYBASIN_S) && (pcolor > STRIPE_OFS);
		// inside colour of the both-axes basin falls back to plain both axes
		if ((m == MODE_XYBASIN || m == MODE_XYBASIN_S) && pcolor == '0) begin
			m = MODE_XYAXIS;
		end
		item.x = px[COORD_BITS-1:0];
		item.y = py[COORD_BITS-1:0];
		item.xd = {1'b0, cfg.x_sum} - (CFG_BITS+1)'(item.x);
		item.yd = {1'b0, cfg.y_sum} - (CFG_BITS+1)'(item.y);
		item.mode = m;
		item.bx = (m == MODE_XBASIN || m == MODE_XBASIN_S);
		item.bxy = (m == MODE_XYBASIN || m == MODE_XYBASIN_S);
		item.stripe = stripe;
		item.c = pcolor;
		item.cu = pcolor - (stripe ? STRIPE_OFS : '0);
	end

endmodule

@@ src/spmw_check.sv @@
// Bound checks, write mask and partner colour of the basin modes.
module spmw_check import spmw_pkg::*; (
	input  pipe_t               item_in,
	input  cfg_t                cfg,
	input  logic [DEG_BITS-1:0] deg,
	output pipe_t               item_out
);

	logic                  xrep;
	logic                  yrep;
	logic                  xhi;
	logic                  xok;
	logic                  yok;
	logic [COLOR_BITS-1:0] deg32;
	logic [COLOR_BITS-1:0] hp2;

	always_comb begin
		item_out = item_in;
		// a mirror must be non-negative and fit the coordinate width
		xrep = !item_in.xd[CFG_BITS] && (item_in.xd[CFG_BITS-1:COORD_BITS] == '0);
		yrep = !item_in.yd[CFG_BITS] && (item_in.yd[CFG_BITS-1:COORD_BITS] == '0);
		xhi = xrep && (item_in.xd[CFG_BITS-1:0] < cfg.width);
		xok = xhi && ($signed(item_in.xd) > $signed({cfg.x_low[CFG_BITS-1], cfg.x_low}));
		yok = yrep && (item_in.yd[CFG_BITS-1:0] < cfg.height)
			&& ($signed(item_in.yd) > $signed({cfg.y_low[CFG_BITS-1], cfg.y_low}));
		item_out.xm = item_in.xd[COORD_BITS-1:0];
		item_out.ym = item_in.yd[COORD_BITS-1:0];

		// partner colour, all arithmetic wraps
		deg32 = COLOR_BITS'(deg);
		hp2 = COLOR_BITS'(deg[DEG_BITS-1:1]) + 32'd2;
		item_out.c1 = (item_in.cu < hp2) ? (hp2 - item_in.cu) : (hp2 + deg32 - item_in.cu);
		item_out.a1 = deg32 + 32'd1 - item_in.cu;

		// slots: original, x mirrored, y mirrored, both mirrored
		item_out.mask = 4'b0001;
		case (item_in.mode) inside
			MODE_XAXIS, MODE_XBASIN, MODE_XBASIN_S: item_out.mask[2] = yok;
			MODE_YAXIS: item_out.mask[1] = xok;
			MODE_XYAXIS: item_out.mask = {yok && xhi, yok, xok, 1'b1};
			MODE_ORIGIN: item_out.mask[3] = yok && xhi;
			MODE_XYBASIN, MODE_XYBASIN_S: item_out.mask = {yok && xhi, yok, xhi, 1'b1};
			default: ;
		endcase
	end

endmodule

@@ src/spmw_rem_step.sv @@
// One digit of the two remainder lanes: restoring steps over eight dividend bits.
module spmw_rem_step import spmw_pkg::*; (
	input  logic [DEG_BITS-1:0]   deg,
	input  logic [DEG_BITS-1:0]   ra_in,
	input  logic [DEG_BITS-1:0]   rb_in,
	input  logic [DIGIT_BITS-1:0] da,
	input  logic [DIGIT_BITS-1:0] db,
	output logic [DEG_BITS-1:0]   ra_out,
	output logic [DEG_BITS-1:0]   rb_out
);

	logic [DEG_BITS:0]   ta;
	logic [DEG_BITS:0]   tb;
	logic [DEG_BITS-1:0] ra;
	logic [DEG_BITS-1:0] rb;

	// remainder stays below deg, so the shifted value is below twice deg
	always_comb begin
		ra = ra_in;
		rb = rb_in;
		ta = '0;
		tb = '0;
		for (int i = DIGIT_BITS - 1; i >= 0; i--) begin
			ta = {ra, da[i]};
			tb = {rb, db[i]};
			if (ta >= {1'b0, deg}) begin
				ta = ta - {1'b0, deg};
			end
			if (tb >= {1'b0, deg}) begin
				tb = tb - {1'b0, deg};
			end
			ra = ta[DEG_BITS-1:0];
			rb = tb[DEG_BITS-1:0];
		end
		ra_out = ra;
		rb_out = rb;
	end

endmodule

@@ src/spmw_emit.sv @@
// Output stage: final colours per slot, then one pixel write per word.
module spmw_emit import spmw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ld_valid,
	input  pipe_t       item,
	output logic        ld_ready,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] wx,
	output logic [15:0] wy,
	output logic [31:0] wcolor,
	output logic        last
);

	logic [3:0]                    pend_q;
	logic [OUT_COORD_BITS-1:0]     slot_x_q [4];
	logic [OUT_COORD_BITS-1:0]     slot_y_q [4];
	logic [COLOR_BITS-1:0]         slot_c_q [4];
	logic [3:0]                    rest;
	logic [1:0]                    sel;
	logic                          out_fire;
	logic                          ld_fire;
	logic [COLOR_BITS-1:0]         sofs;

	// lowest pending slot goes out first
	assign rest = pend_q & (pend_q - 4'd1);
	assign out_valid = (pend_q != '0);
	assign last = out_valid && (rest == '0);
	assign out_fire = out_valid && !out_stall;
	assign ld_ready = !out_valid || (out_fire && last);
	assign ld_fire = ld_valid && ld_ready;
	assign sofs = item.stripe ? STRIPE_OFS : '0;

	always_comb begin
		if (pend_q[0]) begin
			sel = 2'd0;
		end else if (pend_q[1]) begin
			sel = 2'd1;
		end else if (pend_q[2]) begin
			sel = 2'd2;
		end else begin
			sel = 2'd3;
		end
	end

	assign wx = slot_x_q[sel];
	assign wy = slot_y_q[sel];
	assign wcolor = slot_c_q[sel];

	// pending slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (ld_fire) begin
			pend_q <= item.mask;
		end else if (out_fire) begin
			pend_q <= rest;
		end
	end

	// slot words, colours of the basin modes resolved here
	always_ff @(posedge clk) begin
		if (ld_fire) begin
			slot_x_q[0] <= OUT_COORD_BITS'(item.x);
			slot_y_q[0] <= OUT_COORD_BITS'(item.y);
			slot_c_q[0] <= item.c;
			slot_x_q[1] <= OUT_COORD_BITS'(item.xm);
			slot_y_q[1] <= OUT_COORD_BITS'(item.y);
			slot_c_q[1] <= item.bxy ? (item.c1 + sofs) : item.c;
			slot_x_q[2] <= OUT_COORD_BITS'(item.x);
			slot_y_q[2] <= OUT_COORD_BITS'(item.ym);
			slot_c_q[2] <= (item.bx || item.bxy)
				? (COLOR_BITS'(item.ra) + 32'd1 + sofs) : item.c;
			slot_x_q[3] <= OUT_COORD_BITS'(item.xm);
			slot_y_q[3] <= OUT_COORD_BITS'(item.ym);
			slot_c_q[3] <= item.bxy ? (COLOR_BITS'(item.rb) + 32'd1 + sofs) : item.c;
		end
	end

	// a loaded item always shows its first word next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		ld_fire |=> out_valid)
		else $error("loaded item not presented");

	// the final word of an item empties the stage unless another is loaded
	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && last && !ld_valid) |=> !out_valid)
		else $error("words left after final word");

endmodule

@@ src/symmetric_pixel_mirror_writer_top.sv @@
// Top level of the symmetric pixel mirror writer: config, pipeline and output.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+-------------------------------
//  in      | in        | in_valid / in_stall  | px, py, pcolor, abort
//  out     | out       | out_valid / out_stall| wx, wy, wcolor, last
//  cfg     | in        | cfg_we               | cfg_idx, cfg_wdata
//
// An input word is taken every cycle while the output keeps up; after acceptance
// it passes through seven pipeline stages (four of them the digit steps of the
// two remainder lanes) and then the output stage.
// An item then holds the output for one cycle per pixel write, one to four writes,
// while out_stall is low, so the sustained rate is set by the single output port.
// Reset clears all valid bits and loads the register defaults; nothing to sweep.
// out_stall backs up stage by stage; bubbles are filled, nothing is dropped.
module symmetric_pixel_mirror_writer_top import spmw_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [15:0]         px,
	input  logic [15:0]         py,
	input  logic [31:0]         pcolor,
	input  logic                abort,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [15:0]         wx,
	output logic [15:0]         wy,
	output logic [31:0]         wcolor,
	output logic                last,
	input  logic                cfg_we,
	input  logic [IDX_BITS-1:0] cfg_idx,
	input  logic [CFG_BITS-1:0] cfg_wdata
);

	cfg_t                cfg_q;
	logic [DEG_BITS-1:0] deg;

	logic  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic  en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;
	pipe_t pipe_s1, pipe_s2, pipe_s3, pipe_s4, pipe_s5, pipe_s6, pipe_s7;
	pipe_t prep_d, check_d, a2_d, rem4_d, rem5_d, rem6_d, rem7_d;
	logic [DEG_BITS-1:0] ra4, rb4, ra5, rb5, ra6, rb6, ra7, rb7;
	logic  ld_ready;
	logic  in_fire;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode   <= MODE_NONE;
			cfg_q.x_sum  <= '0;
			cfg_q.y_sum  <= '0;
			cfg_q.x_low  <= '0;
			cfg_q.y_low  <= '0;
			cfg_q.width  <= 17'd640;
			cfg_q.height <= 17'd480;
			cfg_q.degree <= 8'd3;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MODE:   cfg_q.mode   <= cfg_wdata[3:0];
				REG_XSUM:   cfg_q.x_sum  <= cfg_wdata;
				REG_YSUM:   cfg_q.y_sum  <= cfg_wdata;
				REG_XLOW:   cfg_q.x_low  <= cfg_wdata;
				REG_YLOW:   cfg_q.y_low  <= cfg_wdata;
				REG_WIDTH:  cfg_q.width  <= cfg_wdata;
				REG_HEIGHT: cfg_q.height <= cfg_wdata;
				REG_DEGREE: cfg_q.degree <= cfg_wdata[DEG_BITS-1:0];
				default: ;
			endcase
		end
	end

	// degree zero behaves as one
	assign deg = (cfg_q.degree == '0) ? DEG_BITS'(1) : cfg_q.degree;

	// stage advance, each stage moves when empty or when the next one moves
	assign en_s7 = !v_s7 || ld_ready;
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign in_stall = !en_s1;
	assign in_fire = in_valid && en_s1;

	// stage logic
	spmw_prep u_prep (
		.px     (px),
		.py     (py),
		.pcolor (pcolor),
		.cfg    (cfg_q),
		.item   (prep_d)
	);

	spmw_check u_check (
		.item_in  (pipe_s1),
		.cfg      (cfg_q),
		.deg      (deg),
		.item_out (check_d)
	);

	always_comb begin
		a2_d = pipe_s2;
		a2_d.a2 = COLOR_BITS'(deg) + 32'd1 - pipe_s2.c1;
		a2_d.ra = '0;
		a2_d.rb = '0;
	end

	always_comb begin
		rem4_d = pipe_s3;
		rem4_d.ra = ra4;
		rem4_d.rb = rb4;
		rem5_d = pipe_s4;
		rem5_d.ra = ra5;
		rem5_d.rb = rb5;
		rem6_d = pipe_s5;
		rem6_d.ra = ra6;
		rem6_d.rb = rb6;
		rem7_d = pipe_s6;
		rem7_d.ra = ra7;
		rem7_d.rb = rb7;
	end

	// remainder lanes, most significant digit first
	spmw_rem_step u_rem4 (
		.deg (deg), .ra_in (pipe_s3.ra), .rb_in (pipe_s3.rb),
		.da (pipe_s3.a1[31:24]), .db (pipe_s3.a2[31:24]),
		.ra_out (ra4), .rb_out (rb4)
	);

	spmw_rem_step u_rem5 (
		.deg (deg), .ra_in (pipe_s4.ra), .rb_in (pipe_s4.rb),
		.da (pipe_s4.a1[23:16]), .db (pipe_s4.a2[23:16]),
		.ra_out (ra5), .rb_out (rb5)
	);

	spmw_rem_step u_rem6 (
		.deg (deg), .ra_in (pipe_s5.ra), .rb_in (pipe_s5.rb),
		.da (pipe_s5.a1[15:8]), .db (pipe_s5.a2[15:8]),
		.ra_out (ra6), .rb_out (rb6)
	);

	spmw_rem_step u_rem7 (
		.deg (deg), .ra_in (pipe_s6.ra), .rb_in (pipe_s6.rb),
		.da (pipe_s6.a1[7:0]), .db (pipe_s6.a2[7:0]),
		.ra_out (ra7), .rb_out (rb7)
	);

	// valid bits; an aborted word is taken but leaves a bubble
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid && !abort;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (en_s1) pipe_s1 <= prep_d;
		if (en_s2) pipe_s2 <= check_d;
		if (en_s3) pipe_s3 <= a2_d;
		if (en_s4) pipe_s4 <= rem4_d;
		if (en_s5) pipe_s5 <= rem5_d;
		if (en_s6) pipe_s6 <= rem6_d;
		if (en_s7) pipe_s7 <= rem7_d;
	end

	spmw_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld_valid  (v_s7),
		.item      (pipe_s7),
		.ld_ready  (ld_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.wx        (wx),
		.wy        (wy),
		.wcolor    (wcolor),
		.last      (last)
	);

	// input is held off only when the first stage is occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1)
		else $error("input stalled with empty first stage");

	// an aborted word never enters the pipeline
	a_abort_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && abort) |=> !v_s1)
		else $error("aborted word entered pipeline");

	// a blocked last stage keeps its item
	a_s7_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s7 && !ld_ready) |=> (v_s7 && $stable(pipe_s7)))
		else $error("last stage lost its item under stall");

endmodule

@@ verif/spmw_write_checker.sv @@
// Checker for the pixel mirror writer: predicts the write stream and compares it.
module spmw_write_checker import spmw_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [15:0]         px,
	input  logic [15:0]         py,
	input  logic [31:0]         pcolor,
	input  logic                abort,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [15:0]         wx,
	input  logic [15:0]         wy,
	input  logic [31:0]         wcolor,
	input  logic                last,
	input  logic                cfg_we,
	input  logic [IDX_BITS-1:0] cfg_idx,
	input  logic [CFG_BITS-1:0] cfg_wdata,
	output int                  mismatches,
	output int                  pending_writes,
	output int                  writes_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [31:0] c;
		logic        last;
	} pixel_write_t;

	cfg_t         regs;
	pixel_write_t expected_writes[$];
	pixel_write_t head;

	// Basin colour partner: ((deg + 1 - c) mod deg) + 1, all modulo 2^32
	function automatic logic [31:0] basin_remap(logic [31:0] c, logic [31:0] deg);
		logic [31:0] t;
		t = deg + 32'd1 - c;
		return t % deg + 32'd1;
	endfunction

	// Works out every write one accepted pixel word causes, in output order
	task automatic predict_pixel_writes(input logic [15:0] x, input logic [15:0] y,
			input logic [31:0] c);
		pixel_write_t batch[$];
		longint       xm, ym;
		logic         xm_ok, ym_ok, x_hi, x_both, y_both;
		logic [31:0]  deg, stripe, cu, half, c1;
		logic [3:0]   m;

		// mirrored coordinates; anything outside 16 bits is dropped
		xm = longint'(regs.x_sum) - longint'(x);
		ym = longint'(regs.y_sum) - longint'(y);
		xm_ok = (xm >= 0) && (xm <= 65535);
		ym_ok = (ym >= 0) && (ym <= 65535);
		x_hi = xm_ok && (xm < longint'(regs.width));
		x_both = x_hi && (xm > longint'($signed(regs.x_low)));
		y_both = ym_ok && (ym < longint'(regs.height)) && (ym > longint'($signed(regs.y_low)));

		// colour terms of the basin modes; degree zero counts as one
		m = regs.mode;
		deg = (regs.degree == '0) ? 32'd1 : 32'(regs.degree);
		stripe = ((m == MODE_XBASIN_S || m == MODE_XYBASIN_S) && c > 32'd8) ? STRIPE_OFS : '0;
		if ((m == MODE_XYBASIN || m == MODE_XYBASIN_S) && c == '0)
			m = MODE_XYAXIS;
		cu = c - stripe;
		half = deg / 32'd2;
		c1 = (cu < half + 32'd2) ? (half + 32'd2 - cu) : (half + deg + 32'd2 - cu);

		// the computed pixel always goes first
		batch.push_back(pixel_write_t'{x, y, c, 1'b0});
		case (m)
		MODE_XAXIS: begin
			if (y_both)
				batch.push_back(pixel_write_t'{x, ym[15:0], c, 1'b0});
		end
		MODE_YAXIS: begin
			if (x_both)
				batch.push_back(pixel_write_t'{xm[15:0], y, c, 1'b0});
		end
		MODE_XYAXIS: begin
			if (x_both)
				batch.push_back(pixel_write_t'{xm[15:0], y, c, 1'b0});
			if (y_both) begin
				batch.push_back(pixel_write_t'{x, ym[15:0], c, 1'b0});
				if (x_hi)
					batch.push_back(pixel_write_t'{xm[15:0], ym[15:0], c, 1'b0});
			end
		end
		MODE_ORIGIN: begin
			if (y_both && x_hi)
				batch.push_back(pixel_write_t'{xm[15:0], ym[15:0], c, 1'b0});
		end
		MODE_XBASIN, MODE_XBASIN_S: begin
			if (y_both)
				batch.push_back(pixel_write_t'{x, ym[15:0],
					basin_remap(cu, deg) + stripe, 1'b0});
		end
		MODE_XYBASIN, MODE_XYBASIN_S: begin
			if (x_hi)
				batch.push_back(pixel_write_t'{xm[15:0], y, c1 + stripe, 1'b0});
			if (y_both) begin
				batch.push_back(pixel_write_t'{x, ym[15:0],
					basin_remap(cu, deg) + stripe, 1'b0});
				if (x_hi)
					batch.push_back(pixel_write_t'{xm[15:0], ym[15:0],
						basin_remap(c1, deg) + stripe, 1'b0});
			end
		end
		default: ;
		endcase
		batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i])
			expected_writes.push_back(batch[i]);
	endtask

	// Sample both channels and the register port on every edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.mode = MODE_NONE;
			regs.x_sum = '0;
			regs.y_sum = '0;
			regs.x_low = '0;
			regs.y_low = '0;
			regs.width = 17'd640;
			regs.height = 17'd480;
			regs.degree = 8'd3;
			expected_writes.delete();
			mismatches = 0;
			writes_checked = 0;
			pending_writes = 0;
		end else begin
			// outgoing word against the oldest expectation
			if (out_valid && !out_stall) begin
				writes_checked++;
				if (expected_writes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected write: x=%0d y=%0d colour=%0d last=%0b",
							wx, wy, wcolor, last);
				end else begin
					head = expected_writes.pop_front();
					if ({wx, wy, wcolor, last} !== head) begin
						mismatches++;
						if (mismatches <= 10)
							$display("write mismatch: expected x=%0d y=%0d colour=%0d last=%0b, got x=%0d y=%0d colour=%0d last=%0b",
								head.x, head.y, head.c, head.last, wx, wy, wcolor, last);
					end
				end
			end
			// incoming pixel word; an aborted one writes nothing
			if (in_valid && !in_stall && !abort)
				predict_pixel_writes(px, py, pcolor);
			// register writes only come while the block is idle
			if (cfg_we) begin
				case (cfg_idx)
				REG_MODE:   regs.mode = cfg_wdata[3:0];
				REG_XSUM:   regs.x_sum = cfg_wdata;
				REG_YSUM:   regs.y_sum = cfg_wdata;
				REG_XLOW:   regs.x_low = cfg_wdata;
				REG_YLOW:   regs.y_low = cfg_wdata;
				REG_WIDTH:  regs.width = cfg_wdata;
				REG_HEIGHT: regs.height = cfg_wdata;
				REG_DEGREE: regs.degree = cfg_wdata[DEG_BITS-1:0];
				default: ;
				endcase
			end
			pending_writes = expected_writes.size();
		end
	end

endmodule

@@ verif/tb_symmetric_pixel_mirror_writer_top.sv @@
// Testbench top for the pixel mirror writer: stimulus, register setups and verdict.
module tb_symmetric_pixel_mirror_writer_top;
	timeunit 1ns;
	timeprecision 1ps;
	import spmw_pkg::*;

	localparam int NUM_SETUPS = 13;
	localparam int RANDOM_PER_SETUP = 26;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 20;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [3:0] MODE_UNUSED = 4'd15;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [15:0]         px = '0;
	logic [15:0]         py = '0;
	logic [31:0]         pcolor = '0;
	logic                abort = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [15:0]         wx;
	logic [15:0]         wy;
	logic [31:0]         wcolor;
	logic                last;
	logic                cfg_we = 1'b0;
	logic [IDX_BITS-1:0] cfg_idx = '0;
	logic [CFG_BITS-1:0] cfg_wdata = '0;

	int   mismatches;
	int   pending_writes;
	int   writes_checked;
	int   words_sent = 0;
	int   idle_pct = 0;
	int   stall_pct = 0;
	int   hold_left = 0;
	int   cycle_count = 0;
	logic hold_req = 1'b0;
	cfg_t setups[NUM_SETUPS];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	symmetric_pixel_mirror_writer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.px        (px),
		.py        (py),
		.pcolor    (pcolor),
		.abort     (abort),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.wx        (wx),
		.wy        (wy),
		.wcolor    (wcolor),
		.last      (last),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	spmw_write_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.px             (px),
		.py             (py),
		.pcolor         (pcolor),
		.abort          (abort),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.wx             (wx),
		.wy             (wy),
		.wcolor         (wcolor),
		.last           (last),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_wdata      (cfg_wdata),
		.mismatches     (mismatches),
		.pending_writes (pending_writes),
		.writes_checked (writes_checked)
	);

	// Write receiver: random stalls, or a long hold-off when asked for
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("watchdog expired after %0d cycles, %0d writes still due",
				cycle_count, pending_writes);
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic cfg_t make_setup(logic [3:0] m, int xs, int ys, int xl, int yl,
			int w, int h, int d);
		cfg_t s;
		s.mode = m;
		s.x_sum = 17'(xs);
		s.y_sum = 17'(ys);
		s.x_low = 17'(xl);
		s.y_low = 17'(yl);
		s.width = 17'(w);
		s.height = 17'(h);
		s.degree = 8'(d);
		return s;
	endfunction

	// Coordinates mostly inside the screen, some around the mirror edges
	function automatic logic [15:0] pick_coord(int span, int mirror_sum);
		int reach;
		reach = (span > 65531) ? 65535 : span + 4;
		case ($urandom_range(7))
		0: return 16'($urandom);
		1: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
		2: return 16'(mirror_sum - int'($urandom_range(3)));
		3: return 16'(mirror_sum - span + int'($urandom_range(2)));
		default: return 16'($urandom_range(reach));
		endcase
	endfunction

	// Colours mostly in the basin range, with stripe and wrap corners
	function automatic logic [31:0] pick_colour(int deg);
		case ($urandom_range(7))
		0: return $urandom;
		1: begin
			case ($urandom_range(3))
			0: return 32'd0;
			1: return 32'd8;
			2: return 32'd9;
			default: return 32'hFFFF_FFFF;
			endcase
		end
		default: return $urandom_range(2 * deg + 20);
		endcase
	endfunction

	task automatic put_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic program_setup(input cfg_t s);
		put_reg(REG_MODE, CFG_BITS'(s.mode));
		put_reg(REG_XSUM, s.x_sum);
		put_reg(REG_YSUM, s.y_sum);
		put_reg(REG_XLOW, s.x_low);
		put_reg(REG_YLOW, s.y_low);
		put_reg(REG_WIDTH, s.width);
		put_reg(REG_HEIGHT, s.height);
		put_reg(REG_DEGREE, CFG_BITS'(s.degree));
		cfg_we <= 1'b0;
	endtask

	// Offer one pixel word and hold it until taken; returns on the accepting edge
	task automatic send_pixel(input logic [15:0] x, input logic [15:0] y,
			input logic [31:0] c, input logic ab);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		px <= x;
		py <= y;
		pcolor <= c;
		abort <= ab;
		do
			@(negedge clk);
		while (in_stall);
		@(posedge clk);
		words_sent++;
	endtask

	// Stop offering and wait for every expected write to leave
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_writes != 0);
		@(posedge clk);
	endtask

	initial begin
		setups[0]  = make_setup(MODE_NONE, 0, 0, 0, 0, 640, 480, 3);
		setups[1]  = make_setup(MODE_XAXIS, 639, 479, -1, -1, 640, 480, 3);
		setups[2]  = make_setup(MODE_YAXIS, 639, 479, 100, 0, 640, 480, 3);
		setups[3]  = make_setup(MODE_XYAXIS, 700, 500, 20, 30, 640, 480, 3);
		setups[4]  = make_setup(MODE_ORIGIN, 639, 479, -1, -1, 640, 480, 3);
		setups[5]  = make_setup(MODE_XBASIN, 639, 479, 0, 0, 640, 480, 3);
		setups[6]  = make_setup(MODE_XYBASIN, 639, 479, -1, -1, 640, 480, 5);
		setups[7]  = make_setup(MODE_XBASIN_S, 255, 255, 10, 10, 256, 256, 7);
		setups[8]  = make_setup(MODE_XYBASIN_S, 131070, 131070, -1, -1, 65536, 65536, 255);
		setups[9]  = make_setup(MODE_XYBASIN, 0, 0, -1, -1, 1, 1, 1);
		setups[10] = make_setup(MODE_UNUSED, 639, 479, -1, -1, 640, 480, 0);
		// degree zero behaves as one root
		setups[11] = make_setup(MODE_XYBASIN_S, 65535, 65535, -1, -1, 65536, 65536, 0);
		// zero screen size drops every mirror
		setups[12] = make_setup(MODE_XYAXIS, 65535, 65535, 65535, 65535, 0, 0, 2);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < NUM_SETUPS; p++) begin
			// rotate through the idling patterns
			case (p % 4)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 48; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 48; end
			default: begin idle_pct = 25; stall_pct = 25; end
			endcase
			program_setup(setups[p]);

			// corner pixels first; the first setup sends an aborted word in place of the far corner
			send_pixel(16'h0000, 16'h0000, 32'd0, 1'b0);
			if (p == 0)
				send_pixel(16'h0123, 16'h0045, 32'd77, 1'b1);
			else
				send_pixel(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);

			// long receiver hold-off so the pipeline fills and backs up
			if (p == 3)
				hold_req = 1'b1;

			for (int i = 0; i < RANDOM_PER_SETUP; i++) begin
				if (p == 5 && i == RANDOM_PER_SETUP / 2)
					wait_for_drain();
				send_pixel(pick_coord(int'(setups[p].width), int'(setups[p].x_sum)),
					pick_coord(int'(setups[p].height), int'(setups[p].y_sum)),
					pick_colour(int'(setups[p].degree)),
					$urandom_range(15) == 0);
			end
			wait_for_drain();
			repeat (SETTLE_CYCLES) @(posedge clk);
		end

		$display("Covered every symmetry mode, an unknown mode, extreme windows,");
		$display("zero screen, zero degree, aborts: %0d words, %0d writes, %0d mismatches",
			words_sent, writes_checked, mismatches);
		if (mismatches == 0 && pending_writes == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ files.f @@
src/spmw_pkg.sv
src/spmw_prep.sv
src/spmw_check.sv
src/spmw_rem_step.sv
src/spmw_emit.sv
src/symmetric_pixel_mirror_writer_top.sv
verif/spmw_write_checker.sv
verif/tb_symmetric_pixel_mirror_writer_top.sv
